// File: rtl/lurl_pkg.sv
`timescale 1ns / 1ps

package lurl_pkg;

   localparam int CHAR_CODE_WIDTH   = 8;
   localparam int LONGEST_WIDTH     = 16;
   localparam int POS_WIDTH_DEF     = 16;
   localparam int ALPHABET_SIZE_DEF = 256;

endpackage

// File: rtl/lurl_req_if.sv
`timescale 1ns / 1ps

interface lurl_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [lurl_pkg::CHAR_CODE_WIDTH-1:0] char_code;
   logic                                 is_last;
   logic                                 is_empty;

   modport source (output valid, output char_code, output is_last, output is_empty,
                   input ready);
   modport sink (input valid, input char_code, input is_last, input is_empty,
                 output ready);
endinterface

// File: rtl/lurl_rsp_if.sv
`timescale 1ns / 1ps

interface lurl_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [lurl_pkg::LONGEST_WIDTH-1:0] longest;
   logic                               overflow;

   modport source (output valid, output longest, output overflow, input ready);
   modport sink (input valid, input longest, input overflow, output ready);
endinterface

// File: rtl/longest_unique_run_length.sv
`timescale 1ns / 1ps
// Longest run without a repeated byte, one string streamed a byte per beat.
// req_bus (sink): char_code, is_last, is_empty. A beat with is_last ends the
// string; a beat with is_empty returns zero and drops any string in progress.
// rsp_bus (source): longest, overflow, one beat per is_last or is_empty beat.
// Throughput: one req beat per cycle, across strings too, unless rsp_bus
// stalls. A result passes the compute stage, then the output register.
// Timing is set by the last-seen position memory: a synchronous read issued
// at accept, then the window update and write-back in the compute stage, with
// the previous write forwarded when it hits the same byte.
// Seen flags live in flip-flops and are cleared at once at reset and at the
// end of each string, so no clearing pass is needed.
// Reset (synchronous, active high) empties the pipeline and output register
// and clears all string state; it is accepted immediately after.
// When rsp_bus stalls with a result pending, one more result beat can wait
// in the compute stage; beats that carry no result keep flowing until then,
// after which req_bus ready drops until the output register is taken.
module longest_unique_run_length #(
   parameter int POS_WIDTH     = lurl_pkg::POS_WIDTH_DEF,
   parameter int ALPHABET_SIZE = lurl_pkg::ALPHABET_SIZE_DEF
) (
   input logic       clock,
   input logic       reset,
   lurl_req_if.sink   req_bus,
   lurl_rsp_if.source rsp_bus
);

   localparam int AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
   localparam int OW = lurl_pkg::LONGEST_WIDTH;
   localparam int EW = POS_WIDTH + OW;
   localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

   logic [POS_WIDTH-1:0] lpos_mem [ALPHABET_SIZE];

   logic                     s1_valid_ff, s1_valid_in;
   logic [AW-1:0]            s1_idx_ff;
   logic                     s1_last_ff;
   logic                     s1_empty_ff;
   logic [POS_WIDTH-1:0]     rd_data_ff;
   logic                     fwd_valid_ff, fwd_valid_in;
   logic [AW-1:0]            fwd_idx_ff;
   logic [POS_WIDTH-1:0]     fwd_pos_ff;
   logic [POS_WIDTH-1:0]     pos_ff, pos_in;
   logic [POS_WIDTH-1:0]     ws_ff, ws_in;
   logic [POS_WIDTH-1:0]     best_ff, best_in;
   logic                     ovfl_ff, ovfl_in;
   logic [ALPHABET_SIZE-1:0] seen_ff, seen_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [OW-1:0]            rsp_longest_ff, rsp_longest_in;
   logic                     rsp_overflow_ff, rsp_overflow_in;

   logic [AW-1:0]        req_idx;
   logic [AW-1:0]        rd_addr;
   logic                 s1_res;
   logic                 s1_fire;
   logic                 accept;
   logic [POS_WIDTH-1:0] lpos;
   logic                 pos_full;
   logic                 hit;
   logic [POS_WIDTH-1:0] ws_new;
   logic [POS_WIDTH-1:0] run;
   logic                 take;
   logic                 mem_wr;
   logic [POS_WIDTH-1:0] best_new;
   logic                 ovfl_new;
   logic [EW-1:0]        best_ext;
   logic                 sat;

   // out-of-range codes fold onto the top symbol
   always_comb begin
      if (int'(req_bus.char_code) >= ALPHABET_SIZE) begin
         req_idx = AW'(ALPHABET_SIZE - 1);
      end else begin
         req_idx = AW'(req_bus.char_code);
      end
   end

   assign s1_res  = s1_empty_ff | s1_last_ff;
   assign s1_fire = s1_valid_ff & ~(s1_res & rsp_valid_ff & ~rsp_bus.ready);
   assign req_bus.ready = ~s1_valid_ff | s1_fire;
   assign accept  = req_bus.valid & req_bus.ready;
   assign rd_addr = req_bus.ready ? req_idx : s1_idx_ff;

   // previous write is not yet visible in the read data
   assign lpos = (fwd_valid_ff && (fwd_idx_ff == s1_idx_ff)) ? fwd_pos_ff : rd_data_ff;

   assign pos_full = (pos_ff == POS_MAX);
   assign hit      = seen_ff[s1_idx_ff] & (lpos >= ws_ff);
   assign ws_new   = hit ? (lpos + POS_WIDTH'(1)) : ws_ff;
   assign run      = pos_ff - ws_new + POS_WIDTH'(1);
   assign take     = ~s1_empty_ff & ~pos_full;
   assign mem_wr   = s1_fire & take;
   assign best_new = (take && (run > best_ff)) ? run : best_ff;
   assign ovfl_new = ovfl_ff | (~s1_empty_ff & pos_full);
   assign best_ext = EW'(best_new);
   assign sat      = |best_ext[EW-1:OW];

   always_comb begin
      s1_valid_in     = s1_valid_ff;
      fwd_valid_in    = fwd_valid_ff;
      pos_in          = pos_ff;
      ws_in           = ws_ff;
      best_in         = best_ff;
      ovfl_in         = ovfl_ff;
      seen_in         = seen_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_bus.ready;
      rsp_longest_in  = rsp_longest_ff;
      rsp_overflow_in = rsp_overflow_ff;

      if (req_bus.ready) begin
         s1_valid_in = accept;
      end

      if (!s1_valid_ff) begin
         fwd_valid_in = 1'b0;
      end else if (s1_fire) begin
         fwd_valid_in = take;
      end

      if (s1_fire) begin
         if (s1_res) begin
            pos_in       = '0;
            ws_in        = '0;
            best_in      = '0;
            ovfl_in      = 1'b0;
            seen_in      = '0;
            rsp_valid_in = 1'b1;
            if (s1_empty_ff) begin
               rsp_longest_in  = '0;
               rsp_overflow_in = 1'b0;
            end else begin
               rsp_longest_in  = sat ? '1 : best_ext[OW-1:0];
               rsp_overflow_in = ovfl_new | sat;
            end
         end else begin
            ovfl_in = ovfl_new;
            if (take) begin
               pos_in             = pos_ff + POS_WIDTH'(1);
               ws_in              = ws_new;
               best_in            = best_new;
               seen_in[s1_idx_ff] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         lpos_mem[s1_idx_ff] <= pos_ff;
      end
      rd_data_ff <= lpos_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_idx_ff   <= req_idx;
         s1_last_ff  <= req_bus.is_last;
         s1_empty_ff <= req_bus.is_empty;
      end
      if (s1_fire) begin
         fwd_idx_ff <= s1_idx_ff;
         fwd_pos_ff <= pos_ff;
      end
      rsp_longest_ff  <= rsp_longest_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         pos_ff       <= '0;
         ws_ff        <= '0;
         best_ff      <= '0;
         ovfl_ff      <= 1'b0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         pos_ff       <= pos_in;
         ws_ff        <= ws_in;
         best_ff      <= best_in;
         ovfl_ff      <= ovfl_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.longest  = rsp_longest_ff;
   assign rsp_bus.overflow = rsp_overflow_ff;

endmodule
